[rtl/pidpic_pkg.sv]
// Package for the clamped positional/incremental PID block.
// Holds field widths, the configuration and operand structs, and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package pidpic_pkg;

  localparam int DataW  = 16;  // setpoint, measurement, error and drive width
  localparam int GainW  = 18;  // Q10.8 gain width
  localparam int LimitW = 15;  // integral clamp magnitude width
  localparam int IndexW = 3;   // configuration register index width
  localparam int OpW    = 18;  // multiplier operand width (second difference needs 18)
  localparam int ProdW  = GainW + OpW;
  localparam int AccW   = ProdW + 2;
  localparam int FracW  = 8;   // fraction bits of the gains

  localparam logic [LimitW-1:0] LimitReset = LimitW'(2500);

  // Register indexes on the configuration port
  localparam logic [IndexW-1:0] REG_GAIN_P = 3'd0;
  localparam logic [IndexW-1:0] REG_GAIN_I = 3'd1;
  localparam logic [IndexW-1:0] REG_GAIN_D = 3'd2;
  localparam logic [IndexW-1:0] REG_MODE   = 3'd3;
  localparam logic [IndexW-1:0] REG_LIMIT  = 3'd4;

  typedef enum logic {
    MODE_POSITIONAL  = 1'b0,
    MODE_INCREMENTAL = 1'b1
  } mode_t;

  typedef struct packed {
    logic signed [GainW-1:0] gain_p;
    logic signed [GainW-1:0] gain_i;
    logic signed [GainW-1:0] gain_d;
    mode_t                   mode;
    logic [LimitW-1:0]       limit;
  } cfg_t;

  // Multiplier operands for the three gain terms
  typedef struct packed {
    logic signed [OpW-1:0] p;
    logic signed [OpW-1:0] i;
    logic signed [OpW-1:0] d;
  } ops_t;

endpackage

[rtl/pidpic_cfg.sv]
// Configuration register file for the PID block.
// Depends on pidpic_pkg (cfg_t, register indexes, reset values).
`timescale 1ns / 1ps

module pidpic_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [pidpic_pkg::IndexW-1:0] cfg_index,
  input  logic [pidpic_pkg::GainW-1:0]  cfg_data,
  output pidpic_pkg::cfg_t              cfg
);
  import pidpic_pkg::*;

  // Register writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p <= '0;
      cfg.gain_i <= '0;
      cfg.gain_d <= '0;
      cfg.mode   <= MODE_POSITIONAL;
      cfg.limit  <= LimitReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN_P: cfg.gain_p <= $signed(cfg_data);
        REG_GAIN_I: cfg.gain_i <= $signed(cfg_data);
        REG_GAIN_D: cfg.gain_d <= $signed(cfg_data);
        REG_MODE:   cfg.mode   <= mode_t'(cfg_data[0]);
        REG_LIMIT:  cfg.limit  <= cfg_data[LimitW-1:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/pidpic_err.sv]
// Input register and error stage: forms the error, updates the integral and
// error history, and registers the three multiplier operands.
// Depends on pidpic_pkg (cfg_t, ops_t, widths).
`timescale 1ns / 1ps

module pidpic_err (
  input  logic                          clk,
  input  logic                          rst,
  input  pidpic_pkg::cfg_t              cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [pidpic_pkg::DataW-1:0] target_value,
  input  logic signed [pidpic_pkg::DataW-1:0] measured_value,
  output logic                          op_valid,
  input  logic                          op_ready,
  output pidpic_pkg::ops_t              ops
);
  import pidpic_pkg::*;

  logic                    s0_valid;
  logic signed [DataW-1:0] s0_target;
  logic signed [DataW-1:0] s0_measured;

  logic signed [DataW-1:0] error_sum;
  logic signed [DataW-1:0] previous_error;
  logic signed [DataW-1:0] second_previous_error;

  logic op_take;
  logic s0_take;
  logic s0_fire;

  logic signed [DataW:0]   diff;
  logic signed [DataW-1:0] err;
  logic signed [DataW:0]   sum_raw;
  logic signed [DataW:0]   lim_pos;
  logic signed [DataW:0]   lim_neg;
  logic signed [DataW:0]   sum_clamped;
  logic signed [DataW:0]   d1;
  logic signed [OpW-1:0]   d2;
  ops_t                    ops_next;

  assign op_take  = !op_valid || op_ready;
  assign s0_take  = !s0_valid || op_take;
  assign s0_fire  = s0_valid && op_take;
  assign in_ready = s0_take;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (s0_take) begin
      s0_valid <= in_valid;
    end
    if (s0_take && in_valid) begin
      s0_target   <= target_value;
      s0_measured <= measured_value;
    end
  end

  // Error, clamped integral and difference terms
  always_comb begin
    diff = {s0_target[DataW-1], s0_target} - {s0_measured[DataW-1], s0_measured};
    if (diff > (DataW+1)'(32767)) begin
      err = DataW'(32767);
    end else if (diff < -(DataW+1)'(32768)) begin
      err = DataW'(-32768);
    end else begin
      err = diff[DataW-1:0];
    end

    sum_raw = {error_sum[DataW-1], error_sum} + {err[DataW-1], err};
    lim_pos = $signed({2'b00, cfg.limit});
    lim_neg = -lim_pos;
    if (sum_raw > lim_pos) begin
      sum_clamped = lim_pos;
    end else if (sum_raw < lim_neg) begin
      sum_clamped = lim_neg;
    end else begin
      sum_clamped = sum_raw;
    end

    d1 = {err[DataW-1], err} - {previous_error[DataW-1], previous_error};
    d2 = OpW'(err) + OpW'(second_previous_error) - (OpW'(previous_error) <<< 1);

    unique case (cfg.mode)
      MODE_POSITIONAL: begin
        ops_next.p = OpW'(err);
        ops_next.i = OpW'(sum_clamped);
        ops_next.d = OpW'(d1);
      end
      MODE_INCREMENTAL: begin
        ops_next.p = OpW'(d1);
        ops_next.i = OpW'(err);
        ops_next.d = d2;
      end
      default: ops_next = '0;
    endcase
  end

  // Controller state, updated as each transaction leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum             <= '0;
      previous_error        <= '0;
      second_previous_error <= '0;
    end else if (s0_fire) begin
      previous_error <= err;
      if (cfg.mode == MODE_POSITIONAL) begin
        error_sum <= sum_clamped[DataW-1:0];
      end else begin
        second_previous_error <= previous_error;
      end
    end
  end

  // Operand register
  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (op_take) begin
      op_valid <= s0_valid;
    end
    if (s0_fire) begin
      ops <= ops_next;
    end
  end

endmodule

[rtl/pidpic_mac.sv]
// Multiply stage and output stage: three gain products, then sum, truncate
// toward zero, saturate and hold in the output register.
// Depends on pidpic_pkg (cfg_t, ops_t, widths).
`timescale 1ns / 1ps

module pidpic_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  pidpic_pkg::cfg_t                    cfg,
  input  logic                                op_valid,
  output logic                                op_ready,
  input  pidpic_pkg::ops_t                    ops,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [pidpic_pkg::DataW-1:0] drive_value
);
  import pidpic_pkg::*;

  logic                    pr_valid;
  logic signed [ProdW-1:0] prod_p;
  logic signed [ProdW-1:0] prod_i;
  logic signed [ProdW-1:0] prod_d;

  logic out_take;
  logic pr_take;

  logic signed [AccW-1:0]       acc;
  logic signed [AccW-FracW-1:0] quot;
  logic signed [DataW-1:0]      drive_next;

  assign out_take = !out_valid || out_ready;
  assign pr_take  = !pr_valid || out_take;
  assign op_ready = pr_take;

  // Product register
  always_ff @(posedge clk) begin
    if (rst) begin
      pr_valid <= 1'b0;
    end else if (pr_take) begin
      pr_valid <= op_valid;
    end
    if (pr_take && op_valid) begin
      prod_p <= cfg.gain_p * ops.p;
      prod_i <= cfg.gain_i * ops.i;
      prod_d <= cfg.gain_d * ops.d;
    end
  end

  // Sum, scale down with truncation toward zero, saturate
  always_comb begin
    acc  = AccW'(prod_p) + AccW'(prod_i) + AccW'(prod_d);
    quot = acc[AccW-1:FracW];
    if (acc[AccW-1] && (acc[FracW-1:0] != '0)) begin
      quot = quot + (AccW-FracW)'(1);
    end
    if (quot > (AccW-FracW)'(32767)) begin
      drive_next = DataW'(32767);
    end else if (quot < -(AccW-FracW)'(32768)) begin
      drive_next = DataW'(-32768);
    end else begin
      drive_next = quot[DataW-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= pr_valid;
    end
    if (pr_valid && out_take) begin
      drive_value <= drive_next;
    end
  end

endmodule

[rtl/pid_position_incremental_clamped_top.sv]
// Discrete PID controller, positional or incremental, with clamped integral.
// Channels: input transaction (target_value, measured_value) on in_valid/in_ready,
// result transaction (drive_value) on out_valid/out_ready, one result per input.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 gain_p,
// 1 gain_i, 2 gain_d, 3 controller_mode, 4 integral_limit); other indexes are
// ignored. Write only while no transaction is in flight.
// Pipeline: input register, error/operand stage, product stage, output
// register. An accepted input passes through each of these registers in
// order before its result is presented.
// Throughput: one transaction per cycle while out_ready is held high; the
// integral and error history are updated in the error stage as a sample leaves
// the input register, so consecutive samples need no gap. Each stage has its
// own handshake: when the receiver stalls, the result holds in the output
// register and up to three more transactions are taken before in_ready drops.
// Reset (rst, synchronous): gains 0, positional mode, integral limit 2500,
// integral and error history cleared, pipeline emptied.
// Depends on pidpic_pkg, pidpic_cfg, pidpic_err, pidpic_mac.
`timescale 1ns / 1ps

module pid_position_incremental_clamped_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [pidpic_pkg::IndexW-1:0]       cfg_index,
  input  logic [pidpic_pkg::GainW-1:0]        cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [pidpic_pkg::DataW-1:0] target_value,
  input  logic signed [pidpic_pkg::DataW-1:0] measured_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [pidpic_pkg::DataW-1:0] drive_value
);
  import pidpic_pkg::*;

  cfg_t cfg;
  ops_t ops;
  logic op_valid;
  logic op_ready;

  pidpic_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pidpic_err u_err (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .target_value   (target_value),
    .measured_value (measured_value),
    .op_valid       (op_valid),
    .op_ready       (op_ready),
    .ops            (ops)
  );

  pidpic_mac u_mac (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .op_valid    (op_valid),
    .op_ready    (op_ready),
    .ops         (ops),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .drive_value (drive_value)
  );

endmodule

[rtl/pidpic_chk.sv]
// Port-level checker for the PID block, bound to the top level.
// Depends on pidpic_pkg (widths) and pid_position_incremental_clamped_top.
`timescale 1ns / 1ps

module pidpic_chk (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [pidpic_pkg::DataW-1:0] drive_value
);

  logic       in_xact;
  logic       out_xact;
  logic [2:0] occ;  // transactions inside the block, four stages at most

  assign in_xact  = in_valid && in_ready;
  assign out_xact = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ + {2'b00, in_xact} - {2'b00, out_xact};
    end
  end

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set right after reset");

  // A stalled result holds its value
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(drive_value))
    else $error("stalled result changed");

  // No more transactions in flight than pipeline stages
  a_occ_bound: assert property (@(posedge clk) disable iff (rst) occ <= 3'd4)
    else $error("more than four transactions in flight");

  // A result is shown only for a transaction that was accepted
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> occ != 3'd0)
    else $error("result without an accepted transaction");

  // With the output register empty, the input side never stalls
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("in_ready low while output register empty");

endmodule

bind pid_position_incremental_clamped_top pidpic_chk u_pidpic_chk (.*);
